/* hw/rtl/llt_pkg.sv */
// package of character codes, token classes and result type for the line lexer
`timescale 1ns / 1ps
`default_nettype none

package llt_pkg;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOT     = 8'h2E;

   typedef enum logic [2:0] {
      CLS_NONE   = 3'd0,
      CLS_WORD   = 3'd1,
      CLS_NUMBER = 3'd2,
      CLS_STRING = 3'd3,
      CLS_SYMBOL = 3'd4,
      CLS_OTHER  = 3'd5
   } token_class_type;

   typedef struct packed {
      logic [7:0]      echo_byte;
      token_class_type token_class;
      logic            token_start;
      logic            line_end;
      logic            comment_line;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == 8'h3A || c == 8'h3D || c == 8'h2A || c == 8'h2F || c == 8'h2B ||
             c == 8'h2D || c == 8'h3C || c == 8'h3E || c == 8'h26 || c == 8'h7C ||
             c == 8'h21 || c == 8'h28 || c == 8'h29;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/line_lexer_token_marker_unit.sv */
// top level of the line lexer: per-byte token classification with output skid stage
`timescale 1ns / 1ps
`default_nettype none

// Tags an ASCII byte stream one byte per request: each byte comes back with
// its token class, a token start flag, an end of line flag and a comment line
// flag. One request is taken every cycle unless req_stall is high; its result
// goes to the output register, or to the skid stage while that is held. The
// lexer mode register is updated in the same cycle the byte is taken, so
// back-to-back bytes run at full rate. The output register and one-entry skid
// stage decouple results, so rsp_stall reaches req_stall only once both are full.
module line_lexer_token_marker_unit
   import llt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_echo_byte,
   output logic [2:0]      rsp_token_class,
   output logic            rsp_token_start,
   output logic            rsp_line_end,
   output logic            rsp_comment_line
);

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_SYMBOL  = 3'd4,
      MODE_COMMENT = 3'd5
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       line_start_ff, line_start_in;
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;
   result_type res;
   logic       accept, out_free, fresh;
   logic [7:0] c;

   assign c        = req_char_byte;
   assign req_stall = skid_valid_ff;
   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      res           = '0;
      res.echo_byte = c;
      res.token_class = CLS_NONE;
      mode_in       = mode_ff;
      line_start_in = line_start_ff;
      fresh         = 1'b0;
      if (c == CH_NEWLINE) begin
         res.line_end     = 1'b1;
         res.comment_line = (mode_ff == MODE_COMMENT);
         mode_in          = MODE_IDLE;
         line_start_in    = 1'b1;
      end else begin
         priority if (line_start_ff && c == CH_HASH) begin
            mode_in          = MODE_COMMENT;
            res.comment_line = 1'b1;
         end else if (mode_ff == MODE_COMMENT) begin
            res.comment_line = 1'b1;
         end else if (mode_ff == MODE_STRING) begin
            res.token_class = CLS_STRING;
            if (c == CH_QUOTE) begin
               mode_in = MODE_IDLE;
            end
         end else if (mode_ff == MODE_WORD && (is_letter(c) || is_digit(c))) begin
            res.token_class = CLS_WORD;
         end else if (mode_ff == MODE_NUMBER && (is_digit(c) || c == CH_DOT)) begin
            res.token_class = CLS_NUMBER;
         end else if (mode_ff == MODE_SYMBOL && is_operator(c)) begin
            res.token_class = CLS_SYMBOL;
         end else begin
            fresh = 1'b1;
         end

         if (fresh) begin
            res.token_start = 1'b1;
            priority if (c == CH_SPACE) begin
               res.token_start = 1'b0;
               mode_in         = MODE_IDLE;
            end else if (is_letter(c)) begin
               res.token_class = CLS_WORD;
               mode_in         = MODE_WORD;
            end else if (is_digit(c)) begin
               res.token_class = CLS_NUMBER;
               mode_in         = MODE_NUMBER;
            end else if (c == CH_QUOTE) begin
               res.token_class = CLS_STRING;
               mode_in         = MODE_STRING;
            end else if (is_operator(c)) begin
               res.token_class = CLS_SYMBOL;
               mode_in         = MODE_SYMBOL;
            end else begin
               res.token_class = CLS_OTHER;
               mode_in         = MODE_IDLE;
            end
         end
         line_start_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         line_start_ff <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            line_start_ff <= line_start_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else if (accept) begin
               out_ff       <= res;
               out_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_echo_byte    = out_ff.echo_byte;
   assign rsp_token_class  = out_ff.token_class;
   assign rsp_token_start  = out_ff.token_start;
   assign rsp_line_end     = out_ff.line_end;
   assign rsp_comment_line = out_ff.comment_line;

endmodule

`default_nettype wire

/* tb/line_lexer_token_marker_unit_tb.sv */
// testbench for the line lexer token marker: random idling, own predictor, per-field checks
`timescale 1ns / 1ps

module line_lexer_token_marker_unit_tb;
   import llt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int OP_COUNT = 13;
   localparam int EXPECT_DEPTH = 1024;
   localparam logic [8*OP_COUNT-1:0] OP_CHARS = ":=*/+-<>&|!()";

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WORD,
      ST_NUMBER,
      ST_STRING,
      ST_SYMBOL,
      ST_COMMENT
   } lex_state_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_echo_byte;
   logic [2:0] rsp_token_class;
   logic       rsp_token_start;
   logic       rsp_line_end;
   logic       rsp_comment_line;

   lex_state_type lex_state = ST_IDLE;
   logic          line_fresh = 1'b1;
   result_type    expect_mem[EXPECT_DEPTH];
   int            wr_count = 0;
   int            rd_count = 0;
   int            error_count = 0;
   int            sent_count = 0;
   int            tick_count = 0;
   int            stall_left = 0;
   bit            idle_on = 1'b1;

   line_lexer_token_marker_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_echo_byte    (rsp_echo_byte),
      .rsp_token_class  (rsp_token_class),
      .rsp_token_start  (rsp_token_start),
      .rsp_line_end     (rsp_line_end),
      .rsp_comment_line (rsp_comment_line)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_op(input logic [7:0] c);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < OP_COUNT; i++) begin
         if (OP_CHARS[8*i +: 8] == c) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic result_type mark_next_byte(input logic [7:0] c);
      result_type m;
      bit         restart;
      m.echo_byte    = c;
      m.token_class  = CLS_NONE;
      m.token_start  = 1'b0;
      m.line_end     = 1'b0;
      m.comment_line = 1'b0;
      restart        = 1'b0;
      if (c == CH_NEWLINE) begin
         m.line_end     = 1'b1;
         m.comment_line = (lex_state == ST_COMMENT);
         lex_state      = ST_IDLE;
         line_fresh     = 1'b1;
      end else begin
         if (line_fresh && c == CH_HASH) begin
            lex_state      = ST_COMMENT;
            m.comment_line = 1'b1;
         end else if (lex_state == ST_COMMENT) begin
            m.comment_line = 1'b1;
         end else if (lex_state == ST_STRING) begin
            m.token_class = CLS_STRING;
            if (c == CH_QUOTE) lex_state = ST_IDLE;
         end else if (lex_state == ST_WORD && (is_alpha(c) || is_num(c))) begin
            m.token_class = CLS_WORD;
         end else if (lex_state == ST_NUMBER && (is_num(c) || c == CH_DOT)) begin
            m.token_class = CLS_NUMBER;
         end else if (lex_state == ST_SYMBOL && is_op(c)) begin
            m.token_class = CLS_SYMBOL;
         end else begin
            restart = 1'b1;
         end
         if (restart) begin
            m.token_start = 1'b1;
            if (c == CH_SPACE) begin
               m.token_start = 1'b0;
               lex_state     = ST_IDLE;
            end else if (is_alpha(c)) begin
               m.token_class = CLS_WORD;
               lex_state     = ST_WORD;
            end else if (is_num(c)) begin
               m.token_class = CLS_NUMBER;
               lex_state     = ST_NUMBER;
            end else if (c == CH_QUOTE) begin
               m.token_class = CLS_STRING;
               lex_state     = ST_STRING;
            end else if (is_op(c)) begin
               m.token_class = CLS_SYMBOL;
               lex_state     = ST_SYMBOL;
            end else begin
               m.token_class = CLS_OTHER;
               lex_state     = ST_IDLE;
            end
         end
         line_fresh = 1'b0;
      end
      return m;
   endfunction

   function automatic logic [7:0] pick_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'($urandom_range("0", "9"));
   endfunction

   function automatic logic [7:0] pick_op();
      return OP_CHARS[8*$urandom_range(0, OP_COUNT-1) +: 8];
   endfunction

   function automatic logic [7:0] pick_line_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_NEWLINE || b == CH_QUOTE);
      return b;
   endfunction

   function automatic logic [7:0] pick_other();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (is_alpha(b) || is_num(b) || is_op(b) || b == CH_QUOTE || b == CH_SPACE ||
             b == CH_NEWLINE);
      return b;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      do @(posedge clock);
      while (req_stall);
      expect_mem[wr_count % EXPECT_DEPTH] = mark_next_byte(c);
      wr_count++;
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (wr_count != rd_count);
   endtask

   task automatic send_random_line();
      int              ntok;
      int              len;
      token_class_type kind;
      if ($urandom_range(0, 9) == 0) begin
         send_char(CH_HASH);
         repeat ($urandom_range(0, 8)) send_char(pick_line_byte());
         send_char(CH_NEWLINE);
         return;
      end
      if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
      ntok = $urandom_range(1, 6);
      for (int i = 0; i < ntok; i++) begin
         kind = token_class_type'($urandom_range(CLS_WORD, CLS_OTHER));
         len  = $urandom_range(1, 5);
         case (kind)
            CLS_WORD: begin
               send_char(pick_letter());
               repeat (len - 1) send_char($urandom_range(0, 2) ? pick_letter() : pick_digit());
            end
            CLS_NUMBER: begin
               send_char(pick_digit());
               repeat (len - 1) send_char($urandom_range(0, 3) ? pick_digit() : CH_DOT);
            end
            CLS_STRING: begin
               send_char(CH_QUOTE);
               repeat (len - 1) send_char(pick_line_byte());
               if (i < ntok - 1 || $urandom_range(0, 3) != 0) send_char(CH_QUOTE);
            end
            CLS_SYMBOL: begin
               repeat (len) send_char(pick_op());
            end
            default: begin
               send_char(pick_other());
            end
         endcase
         if ($urandom_range(0, 2) != 0) send_char(CH_SPACE);
      end
      send_char(CH_NEWLINE);
   endtask

   // comment line, words, numbers, symbols, strings, others, extreme bytes
   task automatic test_directed_lines();
      send_text("#x\nab1+(9.x .#\"a \"\"q\n");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h80);
      send_char(CH_NEWLINE);
   endtask

   task automatic test_random_lines();
      while (sent_count < 560) send_random_line();
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         send_random_line();
         wait_for_drain();
      end
   endtask

   task automatic test_noise();
      repeat (120) begin
         send_char($urandom_range(0, 11) == 0 ? CH_NEWLINE : 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (4) send_random_line();
   endtask

   always @(posedge clock) begin
      int roll;
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            rsp_stall <= 1'b0;
         end else if (roll < 96) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(8, 30);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wr_count == rd_count) begin
            report_mismatch("unexpected result, echo_byte", rsp_echo_byte, 0);
         end else begin
            want = expect_mem[rd_count % EXPECT_DEPTH];
            rd_count++;
            if (rsp_echo_byte !== want.echo_byte)
               report_mismatch("echo_byte", rsp_echo_byte, want.echo_byte);
            if (rsp_token_class !== want.token_class)
               report_mismatch("token_class", rsp_token_class, want.token_class);
            if (rsp_token_start !== want.token_start)
               report_mismatch("token_start", rsp_token_start, want.token_start);
            if (rsp_line_end !== want.line_end)
               report_mismatch("line_end", rsp_line_end, want.line_end);
            if (rsp_comment_line !== want.comment_line)
               report_mismatch("comment_line", rsp_comment_line, want.comment_line);
         end
      end
   end

   always @(posedge clock) begin
      tick_count++;
      if (tick_count > CYCLE_LIMIT) begin
         $display("line_lexer_token_marker_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_lines();
      test_random_lines();
      test_drain_pause();
      test_noise();
      test_back_to_back();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("line_lexer_token_marker_unit_tb: PASS");
      end else begin
         $display("line_lexer_token_marker_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/llt_pkg.sv
hw/rtl/line_lexer_token_marker_unit.sv
tb/line_lexer_token_marker_unit_tb.sv
